### design/uex_pkg.sv
package uex_pkg;

  localparam int MAX_SCHEME_LETTERS = 16;
  // upper end of the letter buffer range; fixes the widths carried in a command
  localparam int LETTERS_LIMIT = 64;
  localparam int HEAD_W = $clog2(LETTERS_LIMIT);
  localparam int COUNT_W = $clog2(LETTERS_LIMIT + 1);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       byte_valid;
    logic       url_start;
    logic       url_end;
    logic       scheme_truncated;
    logic       run_last;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_PASS   = 2'd0,
    CMD_END    = 2'd1,
    CMD_REPLAY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic               last;
    logic               trunc;
    logic [HEAD_W-1:0]  head;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [HEAD_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_url_char(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (is_letter(c) || (c >= 8'h30 && c <= 8'h39)) begin
      hit = 1'b1;
    end else begin
      unique case (c)
        8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26, 8'h24, 8'h2D,
        8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h2C: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

endpackage

### design/url_extractor_stream.sv
// URL extractor: takes text one byte a word and returns the URLs of the form
// <letters>://<url characters> found in it. A byte that opens a URL yields the
// held letters, "://" and itself as n + 4 output words (n letters, at most
// MAX_SCHEME_LETTERS), delivered one per cycle while the output is ready, from
// the letter buffer, one read per cycle on its read port. Bytes inside a URL
// keep flowing into a short command queue meanwhile; the first scanning byte
// after that URL waits until the replay has issued its last word. end_of_text
// on an input word clears the held letters and any open URL after that byte.
// The output register decouples the result side, so a stalled output does not
// stop input until the queue fills.
module url_extractor_stream #(
  parameter int MAX_SCHEME_LETTERS = uex_pkg::MAX_SCHEME_LETTERS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  uex_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output uex_pkg::out_word_t out_data
);

  uex_pkg::cmd_t push_cmd;
  uex_pkg::cmd_t head_cmd;
  uex_pkg::wr_t  wr;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          replay_done;

  uex_front #(
    .MAX_SCHEME_LETTERS(MAX_SCHEME_LETTERS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cmd_push   (cmd_push),
    .cmd_full   (cmd_full),
    .cmd        (push_cmd),
    .wr         (wr),
    .replay_done(replay_done)
  );

  uex_fifo #(
    .DEPTH(uex_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_data(push_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (head_cmd),
    .empty    (cmd_empty)
  );

  uex_back #(
    .MAX_SCHEME_LETTERS(MAX_SCHEME_LETTERS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd        (head_cmd),
    .wr         (wr),
    .replay_done(replay_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### design/uex_fifo.sv
module uex_fifo #(
  parameter int DEPTH = uex_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uex_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output uex_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  uex_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/uex_front.sv
module uex_front #(
  parameter int MAX_SCHEME_LETTERS = uex_pkg::MAX_SCHEME_LETTERS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  uex_pkg::in_word_t in_data,
  output logic              cmd_push,
  input  logic              cmd_full,
  output uex_pkg::cmd_t     cmd,
  output uex_pkg::wr_t      wr,
  input  logic              replay_done
);

  localparam int IDX_W = (MAX_SCHEME_LETTERS > 1) ? $clog2(MAX_SCHEME_LETTERS) : 1;
  localparam int CNT_W = $clog2(MAX_SCHEME_LETTERS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SCHEME_LETTERS - 1);

  logic             parse_mode;
  logic [1:0]       sep;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             pending;

  logic             parse_mode_next;
  logic [1:0]       sep_next;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] count_next;
  logic             ovf_next;
  logic             accept;

  // hold scanning input while an earlier URL replay is still being issued; hold all input while the queue is full
  assign in_ready = !cmd_full && !(pending && !parse_mode);
  assign accept = in_valid && in_ready;

  always_comb begin
    logic [7:0]       c;
    logic             last;
    logic             letter;
    logic             colon;
    logic             slash;
    logic             url;
    logic             clr;
    logic             put;
    logic [CNT_W-1:0] cnt_v;
    logic             ovf_v;
    logic [SUM_W-1:0] sum;

    c = in_data.text_byte;
    last = in_data.end_of_text;
    letter = uex_pkg::is_letter(c);
    url = uex_pkg::is_url_char(c);
    colon = (c == uex_pkg::CHAR_COLON);
    slash = (c == uex_pkg::CHAR_SLASH);
    clr = 1'b0;
    put = 1'b0;
    sum = '0;

    parse_mode_next = parse_mode;
    sep_next = sep;
    head_next = head;
    cmd_push = 1'b0;
    cmd.kind = uex_pkg::CMD_PASS;
    cmd.data = c;
    cmd.last = last;
    cmd.trunc = ovf;
    cmd.head = uex_pkg::HEAD_W'(head);
    cmd.count = uex_pkg::COUNT_W'(count);
    wr.en = 1'b0;
    wr.addr = '0;
    wr.data = c;

    if (accept) begin
      if (parse_mode) begin
        cmd_push = 1'b1;
        if (url) begin
          cmd.kind = uex_pkg::CMD_PASS;
        end else begin
          cmd.kind = uex_pkg::CMD_END;
          parse_mode_next = 1'b0;
          sep_next = 2'd0;
          clr = 1'b1;
        end
      end else begin
        unique case (sep)
          2'd0: begin
            if (letter) begin
              put = 1'b1;
            end else if (colon) begin
              sep_next = 2'd1;
            end else begin
              clr = 1'b1;
            end
          end
          2'd1, 2'd2: begin
            if (slash) begin
              sep_next = sep + 2'd1;
            end else begin
              clr = 1'b1;
              sep_next = colon ? 2'd1 : 2'd0;
              put = letter;
            end
          end
          default: begin
            if (count != '0 && url) begin
              cmd_push = 1'b1;
              cmd.kind = uex_pkg::CMD_REPLAY;
              parse_mode_next = 1'b1;
              sep_next = 2'd0;
            end else begin
              clr = 1'b1;
              sep_next = colon ? 2'd1 : 2'd0;
              put = letter;
            end
          end
        endcase
      end
    end

    cnt_v = clr ? '0 : count;
    ovf_v = clr ? 1'b0 : ovf;

    if (put) begin
      wr.en = 1'b1;
      if (cnt_v == CNT_W'(MAX_SCHEME_LETTERS)) begin
        // full: overwrite the oldest letter and advance the head
        wr.addr = uex_pkg::HEAD_W'(head);
        head_next = (head == LAST_IDX) ? '0 : head + 1'b1;
        ovf_v = 1'b1;
      end else begin
        sum = SUM_W'(head) + SUM_W'(cnt_v);
        if (sum >= SUM_W'(MAX_SCHEME_LETTERS)) begin
          sum = sum - SUM_W'(MAX_SCHEME_LETTERS);
        end
        wr.addr = uex_pkg::HEAD_W'(sum[IDX_W-1:0]);
        cnt_v = cnt_v + 1'b1;
      end
    end

    count_next = cnt_v;
    ovf_next = ovf_v;

    if (accept && last) begin
      parse_mode_next = 1'b0;
      sep_next = 2'd0;
      count_next = '0;
      ovf_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= 1'b0;
      sep <= 2'd0;
      head <= '0;
      count <= '0;
      ovf <= 1'b0;
      pending <= 1'b0;
    end else begin
      parse_mode <= parse_mode_next;
      sep <= sep_next;
      head <= head_next;
      count <= count_next;
      ovf <= ovf_next;
      if (cmd_push && cmd.kind == uex_pkg::CMD_REPLAY) begin
        pending <= 1'b1;
      end else if (replay_done) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

### design/uex_back.sv
module uex_back #(
  parameter int MAX_SCHEME_LETTERS = uex_pkg::MAX_SCHEME_LETTERS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  uex_pkg::cmd_t      cmd,
  input  uex_pkg::wr_t       wr,
  output logic               replay_done,
  output logic               out_valid,
  input  logic               out_ready,
  output uex_pkg::out_word_t out_data
);

  localparam int IDX_W = (MAX_SCHEME_LETTERS > 1) ? $clog2(MAX_SCHEME_LETTERS) : 1;
  localparam int STEP_W = $clog2(MAX_SCHEME_LETTERS + 4);
  localparam int SUM_W = STEP_W + 1;

  logic [7:0] letter_mem [MAX_SCHEME_LETTERS];
  logic [7:0] mem_q;

  uex_pkg::out_word_t item;
  logic               use_mem;
  logic               active;
  uex_pkg::cmd_t      cur;
  logic [STEP_W-1:0]  step;

  uex_pkg::out_word_t item_next;
  logic               use_mem_next;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               load;
  logic               have_word;
  logic               final_word;
  uex_pkg::cmd_t      sel;
  logic [STEP_W-1:0]  sel_step;

  assign load = !out_valid || out_ready;
  assign have_word = active || cmd_valid;
  assign sel = active ? cur : cmd;
  assign sel_step = active ? step : '0;
  assign cmd_pop = load && !active && cmd_valid;

  always_comb begin
    logic [STEP_W-1:0] cnt;
    logic [SUM_W-1:0]  sum;

    cnt = STEP_W'(sel.count);
    sum = SUM_W'(sel.head[IDX_W-1:0]) + SUM_W'(sel_step);
    if (sum >= SUM_W'(MAX_SCHEME_LETTERS)) begin
      sum = sum - SUM_W'(MAX_SCHEME_LETTERS);
    end
    rd_addr = sum[IDX_W-1:0];

    item_next.url_byte = sel.data;
    item_next.byte_valid = 1'b1;
    item_next.url_start = 1'b0;
    item_next.url_end = 1'b0;
    item_next.scheme_truncated = sel.trunc;
    item_next.run_last = 1'b0;
    use_mem_next = 1'b0;
    final_word = 1'b0;

    unique case (sel.kind)
      uex_pkg::CMD_PASS: begin
        item_next.url_end = sel.last;
        item_next.run_last = 1'b1;
      end
      uex_pkg::CMD_END: begin
        item_next.url_byte = uex_pkg::CHAR_NUL;
        item_next.byte_valid = 1'b0;
        item_next.url_end = 1'b1;
        item_next.run_last = 1'b1;
      end
      uex_pkg::CMD_REPLAY: begin
        if (sel_step < cnt) begin
          use_mem_next = 1'b1;
          item_next.url_start = (sel_step == '0);
        end else if (sel_step == cnt) begin
          item_next.url_byte = uex_pkg::CHAR_COLON;
        end else if (sel_step == cnt + STEP_W'(1) || sel_step == cnt + STEP_W'(2)) begin
          item_next.url_byte = uex_pkg::CHAR_SLASH;
        end else begin
          item_next.url_end = sel.last;
          item_next.run_last = 1'b1;
          final_word = 1'b1;
        end
      end
      default: begin
        item_next.byte_valid = 1'b0;
      end
    endcase
  end

  assign rd_en = load && have_word && use_mem_next;
  assign replay_done = load && have_word && sel.kind == uex_pkg::CMD_REPLAY && final_word;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      letter_mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= letter_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
      use_mem <= use_mem_next;
    end
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active <= 1'b0;
      step <= '0;
    end else if (load) begin
      out_valid <= have_word;
      if (have_word && sel.kind == uex_pkg::CMD_REPLAY && !final_word) begin
        active <= 1'b1;
        step <= sel_step + 1'b1;
      end else begin
        active <= 1'b0;
        step <= '0;
      end
    end
  end

  always_comb begin
    out_data = item;
    out_data.url_byte = use_mem ? mem_q : item.url_byte;
  end

endmodule
